### rtl/fau_pkg.sv
// Package for the FIR audio filter unit: sizes, operation codes and the
// command and status structs between controller and datapath.
// No dependencies.
package fau_pkg;

  localparam int TAPS       = 256;            // ring and coefficient depth, power of two
  localparam int TAP_AW     = $clog2(TAPS);   // tap and ring address width
  localparam int CNT_W      = TAP_AW + 1;     // counter wide enough to hold TAPS
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int TAP_CFG_W  = 9;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int FRAC_BITS  = 15;             // Q1.15 coefficients

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_COEF   = 1'b1
  } fau_op_t;

  typedef struct packed {
    logic              clr;       // clearing sweep writes zero to both stores
    logic [TAP_AW-1:0] clr_addr;
    logic              hist_wr;   // store the accepted sample at the ring pointer
    logic              coef_wr;   // store the accepted coefficient
    logic              issue;     // read tap pair for tap index
    logic [TAP_AW-1:0] tap;
    logic              acc_clr;
    logic              load_out;  // copy accumulator into the output register
  } fau_cmd_t;

  typedef struct packed {
    logic busy;                   // multiply-accumulate pipeline holds work
    logic acc_zero;               // accumulator currently zero
  } fau_sts_t;

endpackage

### rtl/fau_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fau_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/fau_datapath.sv
// Datapath of the FIR audio filter unit: history ring and coefficient RAMs,
// multiply and accumulate pipeline, output data register. Uses fau_pkg, fau_ram.
module fau_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fau_pkg::fau_cmd_t         cmd,
  input  logic [fau_pkg::SAMPLE_W-1:0] sample,
  input  logic [fau_pkg::TAP_AW-1:0]   coef_index,
  input  logic [fau_pkg::COEF_W-1:0]   coef_value,
  output fau_pkg::fau_sts_t         sts,
  output logic [fau_pkg::SAMPLE_W-1:0] filtered
);
  import fau_pkg::*;

  logic [TAP_AW-1:0]   ptr_r, ptr_nxt;
  logic [TAP_AW-1:0]   newest_r;
  logic                v1_r, v2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [SAMPLE_W-1:0] acc_r;
  logic [SAMPLE_W-1:0] out_r;
  logic [SAMPLE_W-1:0] term;

  logic                hist_we, coef_we, coef_in_range;
  logic [TAP_AW-1:0]   hist_waddr, coef_waddr, hist_raddr;
  logic [SAMPLE_W-1:0] hist_wdata, hist_rdata;
  logic [COEF_W-1:0]   coef_wdata, coef_rdata;

  assign coef_in_range = ({1'b0, coef_index} < CNT_W'(TAPS));

  assign hist_we    = cmd.clr | cmd.hist_wr;
  assign hist_waddr = cmd.clr ? cmd.clr_addr : ptr_r;
  assign hist_wdata = cmd.clr ? '0 : sample;
  assign coef_we    = cmd.clr | (cmd.coef_wr & coef_in_range);
  assign coef_waddr = cmd.clr ? cmd.clr_addr : coef_index;
  assign coef_wdata = cmd.clr ? '0 : coef_value;

  // ring depth is a power of two, so the address wraps by itself
  assign hist_raddr = newest_r - cmd.tap;
  assign ptr_nxt    = ptr_r + 1'b1;

  fau_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  fau_ram #(.WIDTH(COEF_W), .DEPTH(TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (cmd.tap),
    .rdata (coef_rdata)
  );

  // floor shift, then step up by one for a negative product with a fraction:
  // truncation toward zero, wrapped to 16 bits
  assign term = prod_r[FRAC_BITS +: SAMPLE_W]
              + {{(SAMPLE_W-1){1'b0}}, prod_r[PROD_W-1] & (|prod_r[FRAC_BITS-1:0])};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
    end else begin
      if (cmd.hist_wr) begin
        ptr_r <= ptr_nxt;
      end
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_wr) begin
      newest_r <= ptr_r;
    end
    prod_r <= $signed(hist_rdata) * $signed(coef_rdata);
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + term;
    end
    if (cmd.load_out) begin
      out_r <= acc_r;
    end
  end

  assign sts.busy     = v1_r | v2_r;
  assign sts.acc_zero = (acc_r == '0);
  assign filtered     = out_r;

endmodule

### rtl/fau_ctrl.sv
// Controller of the FIR audio filter unit: clearing sweep, tap sequencing,
// tap count register and output handshake. Uses fau_pkg.
module fau_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tuser,
  output logic                          in_tready,
  input  logic                          cfg_we,
  input  logic [fau_pkg::TAP_CFG_W-1:0] cfg_wdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  fau_pkg::fau_sts_t             sts,
  output fau_pkg::fau_cmd_t             cmd
);
  import fau_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_HOLD
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [TAP_CFG_W-1:0] tap_count_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]     used;
  logic                 in_xfer;
  logic                 slot_free;

  assign used      = (tap_count_r > TAP_CFG_W'(TAPS)) ? CNT_W'(TAPS) : CNT_W'(tap_count_r);
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid & in_tready;
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.clr_addr = cnt_r[TAP_AW-1:0];
    cmd.tap      = cnt_r[TAP_AW-1:0];
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(TAPS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          if (in_tuser == OP_COEF) begin
            cmd.coef_wr = 1'b1;
          end else begin
            cmd.hist_wr = 1'b1;
            cmd.acc_clr = 1'b1;
            cnt_nxt     = '0;
            state_nxt   = (used == '0) ? S_HOLD : S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == used - 1'b1) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      tap_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tap_count_r <= cfg_wdata;
      end
    end
  end

  assign out_tvalid = out_valid_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> slot_free) else $error("result loaded over an untaken result");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (cnt_r < used)) else $error("tap issued past taps in use");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !sts.busy) else $error("input taken while pipeline busy");

  a_coef_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tuser == OP_COEF) |=> (state_r == S_IDLE && !cmd.load_out))
    else $error("coefficient write started a result");

  a_zero_taps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD && used == '0 && $past(state_r) == S_IDLE) |-> sts.acc_zero)
    else $error("zero-tap result not zero");

endmodule

### rtl/fir_audio_filter_unit.sv
// Top level of the FIR audio filter unit: joins controller and datapath.
// Uses fau_pkg, fau_ctrl, fau_datapath.
//
// Direct-form FIR over signed 16-bit samples with Q1.15 coefficients.
// Input channel in_*: in_tuser selects the item kind (0 = sample, 1 = write
// one coefficient). A sample yields one result on out_*; a coefficient write
// yields none. cfg_we/cfg_wdata set the number of taps in use (above 256
// counts as 256, zero gives a zero result).
// Timing: one tap per cycle through a single multiplier fed by the two
// RAM read ports, over N = tap_count capped at 256 taps. The earliest
// transfer of a sample's result falls in the same cycle as the unit takes
// the next item, if one is offered. A coefficient write leaves the unit idle,
// ready for the next item. One item is in work at a time; in_tready is high
// whenever the unit is idle.
// Reset: a clearing sweep over all 256 entries zeroes the history ring and the
// coefficient store; in_tready stays low during it, cfg writes are taken.
// Stall: the finished result waits in the output register, and the next
// item is still taken; a further result holds until out_tready frees it.
module fir_audio_filter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // sample[15:0], coef_index[23:16], coef_value[39:24]
  input  logic [0:0]  in_tuser,   // operation[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // filtered[15:0]
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata   // tap_count[8:0]
);
  import fau_pkg::*;

  fau_cmd_t cmd;
  fau_sts_t sts;

  fau_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser[0]),
    .in_tready  (in_tready),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  fau_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sample     (in_tdata[15:0]),
    .coef_index (in_tdata[23:16]),
    .coef_value (in_tdata[39:24]),
    .sts        (sts),
    .filtered   (out_tdata)
  );

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for fir_audio_filter_unit: random and directed sample and
// coefficient transfers, predicted in-bench and checked result by result.
// Depends on fau_pkg and the unit's RTL.
module tb;
  import fau_pkg::*;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int FLUSH_CYCLES = 300;

  typedef struct packed {
    fau_op_t     op;
    logic [15:0] sample;
    logic [7:0]  coef_index;
    logic [15:0] coef_value;
  } audio_item_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [39:0] in_tdata   = '0;   // sample[15:0], coef_index[23:16], coef_value[39:24]
  logic [0:0]  in_tuser   = '0;   // operation[0]
  logic        out_tready = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [8:0]  cfg_wdata  = '0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [15:0] out_tdata;         // filtered[15:0]

  fir_audio_filter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  audio_item_t pending_items[$];
  logic [15:0] expected_filtered[$];
  int          sender_idle_pct = 0;
  int          recv_stall_pct  = 0;
  int          error_count     = 0;
  int          cycle_count     = 0;
  logic        in_took         = 1'b0;
  audio_item_t drive_item;
  audio_item_t seen_item;
  logic [15:0] want_filtered;

  // filter state mirror
  logic [15:0] hist_ring [TAPS];
  logic [15:0] coef_bank [TAPS];
  logic [7:0]  ring_ptr;
  logic [8:0]  taps_live;

  // Q1.15 product, truncated toward zero, wrapped to 16 bits
  function automatic logic [15:0] q15_product(logic signed [15:0] s, logic signed [15:0] c);
    logic signed [31:0] prod;
    logic [31:0]        mag;
    logic [31:0]        quo;
    prod = s * c;
    mag  = prod[31] ? -prod : prod;
    quo  = mag >> FRAC_BITS;
    if (prod[31]) quo = -quo;
    return quo[15:0];
  endfunction

  task automatic apply_filter_item(input audio_item_t it);
    logic [7:0]  newest;
    logic [15:0] acc;
    int          used;
    if (it.op == OP_COEF) begin
      coef_bank[it.coef_index] = it.coef_value;
    end else begin
      newest           = ring_ptr;
      hist_ring[newest] = it.sample;
      ring_ptr         = ring_ptr + 8'd1;
      used             = (taps_live > TAPS) ? TAPS : int'(taps_live);
      acc              = '0;
      for (int k = 0; k < used; k++) begin
        acc = acc + q15_product(hist_ring[newest - 8'(k)], coef_bank[k]);
      end
      expected_filtered = {expected_filtered, acc};
    end
  endtask

  // append one item to the driver's queue
  task automatic queue_item(input audio_item_t it);
    pending_items = {pending_items, it};
  endtask

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(3))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  function automatic audio_item_t sample_item(logic [15:0] value);
    audio_item_t it;
    it.op         = OP_SAMPLE;
    it.sample     = value;
    it.coef_index = 8'($urandom);
    it.coef_value = 16'($urandom);
    return it;
  endfunction

  function automatic audio_item_t coef_item(logic [7:0] index, logic [15:0] value);
    audio_item_t it;
    it.op         = OP_COEF;
    it.sample     = 16'($urandom);
    it.coef_index = index;
    it.coef_value = value;
    return it;
  endfunction

  // mostly samples; coefficient writes mostly aim at the first hot_span taps
  function automatic audio_item_t random_item(int hot_span);
    audio_item_t it;
    it.op         = ($urandom_range(99) < 70) ? OP_SAMPLE : OP_COEF;
    it.sample     = 16'($urandom);
    it.coef_index = 8'($urandom);
    it.coef_value = 16'($urandom);
    if ($urandom_range(9) == 0) it.sample = pick_extreme();
    if ($urandom_range(9) == 0) it.coef_value = pick_extreme();
    if ($urandom_range(4) != 0) it.coef_index = 8'($urandom_range(hot_span - 1));
    return it;
  endfunction

  // driver: hold each transfer until taken, then present the next one or idle
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_took)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        drive_item = pending_items.pop_front();
        in_tdata  <= {drive_item.coef_value, drive_item.coef_index, drive_item.sample};
        in_tuser  <= drive_item.op;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took   <= 1'b0;
      ring_ptr  = '0;
      taps_live = '0;
      for (int i = 0; i < TAPS; i++) begin
        hist_ring[i] = '0;
        coef_bank[i] = '0;
      end
    end else begin
      in_took <= in_tvalid && (in_tready === 1'b1);
      if (cfg_we) taps_live = cfg_wdata;
      if (in_tvalid && (in_tready === 1'b1)) begin
        seen_item.op         = fau_op_t'(in_tuser[0]);
        seen_item.sample     = in_tdata[15:0];
        seen_item.coef_index = in_tdata[23:16];
        seen_item.coef_value = in_tdata[39:24];
        apply_filter_item(seen_item);
      end
      if (out_tvalid === 1'b1 && out_tready) begin
        if (expected_filtered.size() == 0) begin
          $error("filtered: expected no result, actual %0d", $signed(out_tdata));
          error_count++;
        end else begin
          want_filtered = expected_filtered.pop_front();
          if (out_tdata !== want_filtered) begin
            $error("filtered: expected %0d, actual %0d",
                   $signed(want_filtered), $signed(out_tdata));
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic write_taps(input logic [8:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every transfer is out and every result is back
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_tvalid || expected_filtered.size() != 0);
    // let a trailing coefficient write settle
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [8:0] tap_sel;
    int         n_items;
    int         hot_span;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // no taps in use: every result is zero
    write_taps(9'd0);
    queue_item(sample_item(16'h7fff));
    queue_item(sample_item(16'h8000));
    queue_item(coef_item(8'd0, 16'h8000));
    queue_item(coef_item(8'd1, 16'h7fff));
    queue_item(coef_item(8'd255, 16'hffff));
    queue_item(coef_item(8'd2, 16'h0001));
    queue_item(sample_item(16'h5555));
    wait_idle();

    // two taps: most negative squared wraps, small products truncate to zero
    write_taps(9'd2);
    queue_item(sample_item(16'h8000));
    queue_item(sample_item(16'h8000));
    queue_item(sample_item(16'h7fff));
    queue_item(sample_item(16'hffff));
    queue_item(sample_item(16'h0001));
    wait_idle();

    // tap count above the table saturates; history still mostly empty
    write_taps(9'd300);
    queue_item(sample_item(16'h1234));
    queue_item(coef_item(8'd128, 16'h4000));
    queue_item(sample_item(16'hedcb));
    wait_idle();

    write_taps(9'd256);
    queue_item(sample_item(16'h8000));
    queue_item(sample_item(16'h7fff));
    wait_idle();

    write_taps(9'd511);
    queue_item(sample_item(16'hffff));
    queue_item(sample_item(16'h0000));
    wait_idle();

    for (int ph = 0; ph < 16; ph++) begin
      if (ph == 5) begin
        tap_sel = 9'd511;
        n_items = 40;
      end else if (ph == 10) begin
        tap_sel = 9'd256;
        n_items = 40;
      end else if (ph == 3) begin
        tap_sel = 9'd0;
        n_items = 150;
      end else begin
        tap_sel = 9'($urandom_range(24, 1));
        n_items = 125;
      end
      write_taps(tap_sel);
      case (ph % 4)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 52;
          recv_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 52;
        end
        default: begin
          sender_idle_pct = 9;
          recv_stall_pct  = 9;
        end
      endcase
      hot_span = (tap_sel == 0) ? 16 : ((tap_sel > TAPS) ? TAPS : int'(tap_sel));
      for (int i = 0; i < n_items; i++) begin
        queue_item(random_item(hot_span));
      end
      wait_idle();
    end

    repeat (FLUSH_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_filtered.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/fau_pkg.sv
rtl/fau_ram.sv
rtl/fau_datapath.sv
rtl/fau_ctrl.sv
rtl/fir_audio_filter_unit.sv
test/tb.sv
